// File: src/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master slot timer.
// Used by the front end, the tick queue, the slot engine and the top level.
// No dependencies.
package owm_pkg;

    // Operation codes carried by the func field and held as the engine's mode.
    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_RESET = 2'd1,
        OP_BIT   = 2'd2,
        OP_BYTE  = 2'd3
    } op_mode_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_RELEASE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_SAMPLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_END     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_RELEASE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_RELEASE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_SAMPLE    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_END       = 3'd6;

    // Register width and reset values, in ticks of 1/16 us.
    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] RST_RESET_RELEASE = 16'd960;
    localparam logic [TICK_W-1:0] RST_RESET_SAMPLE  = 16'd1104;
    localparam logic [TICK_W-1:0] RST_RESET_END     = 16'd1920;
    localparam logic [TICK_W-1:0] RST_ONE_RELEASE   = 16'd17;
    localparam logic [TICK_W-1:0] RST_ZERO_RELEASE  = 16'd160;
    localparam logic [TICK_W-1:0] RST_BIT_SAMPLE    = 16'd48;
    localparam logic [TICK_W-1:0] RST_BIT_END       = 16'd320;

    // Depth of the queue between front end and engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bits per byte sequence; the slot index counts through them.
    localparam int BYTE_BITS = 8;
    localparam int BIDX_W    = $clog2(BYTE_BITS);

    // One classified tick item.
    typedef struct packed {
        logic           start;
        op_mode_t       op;
        logic [7:0]     data;
        logic           level;
    } tick_item_t;

    // Timing configuration as seen by the engine.
    typedef struct packed {
        logic [TICK_W-1:0] reset_release;
        logic [TICK_W-1:0] reset_sample;
        logic [TICK_W-1:0] reset_end;
        logic [TICK_W-1:0] one_release;
        logic [TICK_W-1:0] zero_release;
        logic [TICK_W-1:0] bit_sample;
        logic [TICK_W-1:0] bit_end;
    } timing_cfg_t;

    // Queue status toward the front end and the engine.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: src/owm_front.sv
// Front end: takes tick items off the input channel and classifies them.
// Depends on owm_pkg; feeds owm_queue.
module owm_front
    import owm_pkg::*;
(
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    func,
    input  logic [7:0]    send_byte,
    input  logic          line_level,
    input  queue_status_t q_status,
    output logic          push,
    output tick_item_t    push_item
);

    // The channel stalls only when the queue has no free entry.
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // Decode the function code into a start flag and an operation.
    always_comb
    begin
        push_item.op    = op_mode_t'(func);
        push_item.start = (op_mode_t'(func) != OP_IDLE);
        push_item.data  = send_byte;
        push_item.level = line_level;
    end

endmodule

// File: src/owm_queue.sv
// Short first-in first-out queue of classified tick items.
// Depends on owm_pkg; sits between owm_front and owm_engine.
module owm_queue
    import owm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tick_item_t    push_item,
    input  logic          pop,
    output tick_item_t    head_item,
    output queue_status_t status
);

    tick_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_item    = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops, both allowed in one cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/owm_engine.sv
// Slot engine: runs reset, bit and byte sequences one tick per queued item
// and holds the result in an output register. Depends on owm_pkg.
module owm_engine
    import owm_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  timing_cfg_t   cfg,
    input  tick_item_t    item,
    input  logic          item_valid,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          drive_low,
    output logic          busy_res,
    output logic          done_res,
    output logic          presence,
    output logic [7:0]    received,
    output logic          echo_mismatch
);

    op_mode_t                 mode_reg,    mode_next;
    logic [COUNTER_BITS-1:0]  cnt_reg,     cnt_next;
    logic [BIDX_W-1:0]        idx_reg,     idx_next;
    logic [7:0]               send_reg,    send_next;
    logic [7:0]               rshift_reg,  rshift_next;
    logic [7:0]               copy_reg,    copy_next;
    logic                     samp_reg,    samp_next;
    logic                     drive_reg,   drive_next;
    logic                     out_valid_reg;
    logic                     done_next;
    logic                     pres_next;
    logic                     mism_next;
    logic [7:0]               recv_next;
    logic                     drive_out_reg, busy_out_reg, done_out_reg, pres_out_reg;
    logic                     mism_out_reg;
    logic [7:0]               recv_out_reg;
    logic [COUNTER_BITS-1:0]  cnt_inc;
    logic [COUNTER_BITS-1:0]  rel_tick, smp_tick, end_tick;
    logic [7:0]               rshift_shifted;

    // An item advances the engine whenever the output register can take a result.
    assign pop = item_valid && (!out_valid_reg || !out_stall);

    // Event ticks for the running operation, masked to the counter width.
    always_comb
    begin
        if (mode_reg == OP_RESET)
        begin
            rel_tick = COUNTER_BITS'(cfg.reset_release);
            smp_tick = COUNTER_BITS'(cfg.reset_sample);
            end_tick = COUNTER_BITS'(cfg.reset_end);
        end
        else
        begin
            rel_tick = send_reg[0] ? COUNTER_BITS'(cfg.one_release)
                                   : COUNTER_BITS'(cfg.zero_release);
            smp_tick = COUNTER_BITS'(cfg.bit_sample);
            end_tick = COUNTER_BITS'(cfg.bit_end);
        end
    end

    assign cnt_inc        = cnt_reg + COUNTER_BITS'(1);
    assign rshift_shifted = {samp_next, rshift_reg[7:1]};

    // Next state for one tick.
    always_comb
    begin
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        send_next   = send_reg;
        rshift_next = rshift_reg;
        copy_next   = copy_reg;
        samp_next   = samp_reg;
        drive_next  = drive_reg;
        done_next   = 1'b0;
        pres_next   = 1'b0;
        mism_next   = 1'b0;
        recv_next   = 8'd0;
        if (mode_reg == OP_IDLE)
        begin
            if (item.start)
            begin
                mode_next   = item.op;
                cnt_next    = '0;
                idx_next    = '0;
                send_next   = item.data;
                copy_next   = item.data;
                rshift_next = 8'd0;
                if (item.op == OP_RESET)
                begin
                    samp_next = 1'b1;
                end
            end
        end
        else
        begin
            cnt_next = cnt_inc;
            // Events at the new count act in a fixed order: pull, release, sample, end.
            if (cnt_inc == COUNTER_BITS'(1))
            begin
                drive_next = 1'b1;
            end
            if (cnt_inc == rel_tick)
            begin
                drive_next = 1'b0;
            end
            if (cnt_inc == smp_tick)
            begin
                samp_next = item.level;
            end
            if (cnt_inc == end_tick)
            begin
                case (mode_reg)
                    OP_RESET:
                    begin
                        done_next = 1'b1;
                        pres_next = !samp_next;
                        mode_next = OP_IDLE;
                    end
                    OP_BIT:
                    begin
                        done_next = 1'b1;
                        recv_next = {7'd0, samp_next};
                        mism_next = (samp_next != copy_reg[0]);
                        mode_next = OP_IDLE;
                    end
                    OP_BYTE:
                    begin
                        rshift_next = rshift_shifted;
                        send_next   = {1'b0, send_reg[7:1]};
                        if (idx_reg == BIDX_W'(BYTE_BITS - 1))
                        begin
                            done_next = 1'b1;
                            recv_next = rshift_shifted;
                            mism_next = (rshift_shifted != copy_reg);
                            mode_next = OP_IDLE;
                            idx_next  = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + BIDX_W'(1);
                            cnt_next = '0;
                        end
                    end
                    default:
                    begin
                        mode_next = OP_IDLE;
                    end
                endcase
            end
        end
    end

    // State and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= OP_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            send_reg      <= 8'd0;
            rshift_reg    <= 8'd0;
            copy_reg      <= 8'd0;
            samp_reg      <= 1'b1;
            drive_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_out_reg <= 1'b0;
            busy_out_reg  <= 1'b0;
            done_out_reg  <= 1'b0;
            pres_out_reg  <= 1'b0;
            recv_out_reg  <= 8'd0;
            mism_out_reg  <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= item_valid;
            end
            if (pop)
            begin
                mode_reg      <= mode_next;
                cnt_reg       <= cnt_next;
                idx_reg       <= idx_next;
                send_reg      <= send_next;
                rshift_reg    <= rshift_next;
                copy_reg      <= copy_next;
                samp_reg      <= samp_next;
                drive_reg     <= drive_next;
                drive_out_reg <= drive_next;
                busy_out_reg  <= (mode_next != OP_IDLE);
                done_out_reg  <= done_next;
                pres_out_reg  <= pres_next;
                recv_out_reg  <= recv_next;
                mism_out_reg  <= mism_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = drive_out_reg;
    assign busy_res      = busy_out_reg;
    assign done_res      = done_out_reg;
    assign presence      = pres_out_reg;
    assign received      = recv_out_reg;
    assign echo_mismatch = mism_out_reg;

endmodule

// File: src/one_wire_master_slot_timer.sv
// Top level of the 1-Wire bus master slot timer: configuration registers,
// front end, tick queue and slot engine. Depends on owm_pkg and the owm_* modules.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ----------------------------------------------
//   in        in_valid / in_stall  func, send_byte, line_level (one tick)
//   out       out_valid/out_stall  drive_low, busy_res, done_res, presence,
//                                  received, echo_mismatch
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One tick item is accepted per clock cycle while the queue has a free entry.
// The queue stores it at the accepting edge; the engine loads its result into the
// output register when it pops the item, once that register can take a result.
// The engine updates once per cycle, for one item per cycle while out_stall is low.
// Reset clears the queue, puts the engine in idle and loads the default timings.
// A stall on the output holds the result; the two-entry queue then fills and
// stalls the input.
module one_wire_master_slot_timer
    import owm_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             func,
    input  logic [7:0]             send_byte,
    input  logic                   line_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   drive_low,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   presence,
    output logic [7:0]             received,
    output logic                   echo_mismatch,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data
);

    timing_cfg_t   cfg_reg;
    queue_status_t q_status;
    tick_item_t    push_item;
    tick_item_t    head_item;
    logic          push;
    logic          pop;

    assign cfg_ready = 1'b1;

    // Timing registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_release <= RST_RESET_RELEASE;
            cfg_reg.reset_sample  <= RST_RESET_SAMPLE;
            cfg_reg.reset_end     <= RST_RESET_END;
            cfg_reg.one_release   <= RST_ONE_RELEASE;
            cfg_reg.zero_release  <= RST_ZERO_RELEASE;
            cfg_reg.bit_sample    <= RST_BIT_SAMPLE;
            cfg_reg.bit_end       <= RST_BIT_END;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RESET_RELEASE: cfg_reg.reset_release <= cfg_data;
                REG_RESET_SAMPLE:  cfg_reg.reset_sample  <= cfg_data;
                REG_RESET_END:     cfg_reg.reset_end     <= cfg_data;
                REG_ONE_RELEASE:   cfg_reg.one_release   <= cfg_data;
                REG_ZERO_RELEASE:  cfg_reg.zero_release  <= cfg_data;
                REG_BIT_SAMPLE:    cfg_reg.bit_sample    <= cfg_data;
                REG_BIT_END:       cfg_reg.bit_end       <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input side.
    owm_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .send_byte  (send_byte),
        .line_level (line_level),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    // Decoupling queue.
    owm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    // Slot timing and result register.
    owm_engine #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item          (head_item),
        .item_valid    (!q_status.empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .presence      (presence),
        .received      (received),
        .echo_mismatch (echo_mismatch)
    );

endmodule

// File: src/owm_checker.sv
// Port-level checks for the 1-Wire bus master slot timer, bound to the top level.
// Depends only on the top level's ports.
module owm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       drive_low,
    input logic       busy_res,
    input logic       done_res,
    input logic       presence,
    input logic [7:0] received,
    input logic       echo_mismatch
);

    // A completing tick is never also reported busy.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done_res with busy_res");

    // Presence and mismatch are reported only on completion.
    a_flags_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (presence || echo_mismatch) |-> done_res)
        else $error("status flag without done_res");

    // Read data stays zero except on a completing tick.
    a_received_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (received != 8'd0) |-> done_res)
        else $error("received data without done_res");

    // A reset completion reports no read data or mismatch.
    a_presence_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && presence |-> (received == 8'd0) && !echo_mismatch)
        else $error("presence together with slot results");

    // A stalled result is held.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_low) && $stable(busy_res)
            && $stable(done_res) && $stable(received))
        else $error("stalled result changed");

endmodule

bind one_wire_master_slot_timer owm_checker u_owm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_low     (drive_low),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .presence      (presence),
    .received      (received),
    .echo_mismatch (echo_mismatch)
);
